>>> rtl/core/mndf_pkg.sv
// ----------------------------------------------------------------------------
// mndf_pkg: shared definitions for the neighbor difference filter
// Sizes, register codes, sequencer states and the structs that travel
// between the front, the queue, the back end and the geometry unit.
// ----------------------------------------------------------------------------
package mndf_pkg;

  // Frame and sample limits.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int SAMPLE_BITS = 16;

  // Derived widths.
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_DATA_BITS = 9;
  localparam int CFG_IDX_BITS  = 1;
  localparam int POS_BITS      = 17;
  localparam int DIV_CNT_BITS  = $clog2(POS_BITS);
  localparam int GRAD_BITS     = 16;
  localparam int COORD_BITS    = 8;

  // Reset geometry.
  localparam logic [CFG_DATA_BITS-1:0] RESET_SIZE   = 9'd256;
  localparam logic [POS_BITS-1:0]      RESET_PIXELS = 17'd65536;
  localparam logic [POS_BITS-1:0]      RESET_TOTAL  = 17'd65793;
  localparam logic [CFG_DATA_BITS-1:0] MIN_SIZE     = 9'd3;
  localparam logic [CFG_DATA_BITS-1:0] MAX_W_SIZE   = CFG_DATA_BITS'(MAX_WIDTH);
  localparam logic [CFG_DATA_BITS-1:0] MAX_H_SIZE   = CFG_DATA_BITS'(MAX_HEIGHT);

  // Window queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCNT_BITS-1:0] QCNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Geometry sequencer states.
  typedef enum logic [2:0] {
    GEOM_IDLE,
    GEOM_SIZE,
    GEOM_MUL,
    GEOM_TOTAL,
    GEOM_CHECK,
    GEOM_DIV
  } geom_state_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Geometry and position reload from the geometry unit to the front.
  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] eff_w;
    logic [CFG_DATA_BITS-1:0] eff_h;
    logic [POS_BITS-1:0]      total;
    logic                     busy;
    logic                     load;
    logic                     clear;
    logic [COL_BITS-1:0]      col;
    logic [ROW_BITS-1:0]      row;
  } geom_ctl_t;

  // One masked 3x3 window with the coordinates of its center pixel.
  typedef struct packed {
    sample_t [8:0]         win;
    logic [COORD_BITS-1:0] qr;
    logic [COORD_BITS-1:0] qc;
    logic                  done;
  } win_entry_t;

endpackage

>>> rtl/core/mndf_if.sv
// ----------------------------------------------------------------------------
// mndf_if: stream channels of the neighbor difference filter
// Valid/ready channels for input samples and for gradient results.
// ----------------------------------------------------------------------------
interface mndf_in_if;
  logic                 valid;
  logic                 ready;
  mndf_pkg::sample_t    sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface mndf_out_if;
  logic                                valid;
  logic                                ready;
  logic [mndf_pkg::GRAD_BITS-1:0]      gradient;
  logic [mndf_pkg::COORD_BITS-1:0]     pixel_row;
  logic [mndf_pkg::COORD_BITS-1:0]     pixel_col;
  logic                                frame_done;

  modport source (output valid, output gradient, output pixel_row, output pixel_col,
                  output frame_done, input ready);
  modport sink (input valid, input gradient, input pixel_row, input pixel_col,
                input frame_done, output ready);
endinterface

>>> rtl/core/mndf_ram.sv
// ----------------------------------------------------------------------------
// mndf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mndf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mndf_geom.sv
// ----------------------------------------------------------------------------
// mndf_geom: frame geometry and position recalculation
// Holds the size registers, derives clamped sizes and item count, and after
// a size change splits the kept position into row and column by division.
// ----------------------------------------------------------------------------
module mndf_geom (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mndf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mndf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic [mndf_pkg::POS_BITS-1:0]       pos,
  output mndf_pkg::geom_ctl_t                 ctl
);

  mndf_pkg::geom_state_t state_r, state_nxt;

  logic [mndf_pkg::CFG_DATA_BITS-1:0] width_cfg_r, height_cfg_r;
  logic [mndf_pkg::CFG_DATA_BITS-1:0] eff_w_r, eff_h_r;
  logic [mndf_pkg::POS_BITS-1:0]      pixels_r, total_r;
  logic [mndf_pkg::DIV_CNT_BITS-1:0]  bit_idx_r;
  logic [mndf_pkg::COL_BITS-1:0]      rem_r, rem_nxt;
  logic [mndf_pkg::ROW_BITS-1:0]      quo_r, quo_nxt;

  logic [mndf_pkg::CFG_DATA_BITS-1:0]   clamp_w, clamp_h;
  logic [2*mndf_pkg::CFG_DATA_BITS-1:0] prod;
  logic [mndf_pkg::COL_BITS:0]          trial, trial_sub;
  logic                                 trial_ge;
  logic                                 past_end;

  // Clamp the raw sizes into the supported range.
  always_comb begin
    if (width_cfg_r < mndf_pkg::MIN_SIZE) begin
      clamp_w = mndf_pkg::MIN_SIZE;
    end else if (width_cfg_r > mndf_pkg::MAX_W_SIZE) begin
      clamp_w = mndf_pkg::MAX_W_SIZE;
    end else begin
      clamp_w = width_cfg_r;
    end
    if (height_cfg_r < mndf_pkg::MIN_SIZE) begin
      clamp_h = mndf_pkg::MIN_SIZE;
    end else if (height_cfg_r > mndf_pkg::MAX_H_SIZE) begin
      clamp_h = mndf_pkg::MAX_H_SIZE;
    end else begin
      clamp_h = height_cfg_r;
    end
  end

  assign prod     = eff_w_r * eff_h_r;
  assign past_end = (pos >= total_r);

  // One restoring division step per cycle, most significant position bit first.
  always_comb begin
    trial     = {rem_r, pos[bit_idx_r]};
    trial_ge  = (trial >= eff_w_r);
    trial_sub = trial - eff_w_r;
    rem_nxt   = trial_ge ? trial_sub[mndf_pkg::COL_BITS-1:0]
                         : trial[mndf_pkg::COL_BITS-1:0];
    quo_nxt   = {quo_r[mndf_pkg::ROW_BITS-2:0], trial_ge};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = mndf_pkg::GEOM_SIZE;
    end else begin
      case (state_r)
        mndf_pkg::GEOM_IDLE:  state_nxt = mndf_pkg::GEOM_IDLE;
        mndf_pkg::GEOM_SIZE:  state_nxt = mndf_pkg::GEOM_MUL;
        mndf_pkg::GEOM_MUL:   state_nxt = mndf_pkg::GEOM_TOTAL;
        mndf_pkg::GEOM_TOTAL: state_nxt = mndf_pkg::GEOM_CHECK;
        mndf_pkg::GEOM_CHECK: begin
          state_nxt = past_end ? mndf_pkg::GEOM_IDLE : mndf_pkg::GEOM_DIV;
        end
        mndf_pkg::GEOM_DIV: begin
          state_nxt = (bit_idx_r == '0) ? mndf_pkg::GEOM_IDLE : mndf_pkg::GEOM_DIV;
        end
        default: state_nxt = mndf_pkg::GEOM_IDLE;
      endcase
    end
  end

  // Outputs toward the front.
  always_comb begin
    ctl.eff_w = eff_w_r;
    ctl.eff_h = eff_h_r;
    ctl.total = total_r;
    ctl.busy  = (state_r != mndf_pkg::GEOM_IDLE);
    ctl.load  = 1'b0;
    ctl.clear = 1'b0;
    ctl.col   = '0;
    ctl.row   = '0;
    case (state_r)
      mndf_pkg::GEOM_CHECK: begin
        ctl.load  = past_end;
        ctl.clear = past_end;
      end
      mndf_pkg::GEOM_DIV: begin
        ctl.load = (bit_idx_r == '0);
        ctl.col  = rem_nxt;
        ctl.row  = quo_nxt;
      end
      default: begin
        ctl.load = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mndf_pkg::GEOM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Size registers written by the host.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= mndf_pkg::RESET_SIZE;
      height_cfg_r <= mndf_pkg::RESET_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        mndf_pkg::CFG_FRAME_WIDTH:  width_cfg_r  <= cfg_wdata;
        mndf_pkg::CFG_FRAME_HEIGHT: height_cfg_r <= cfg_wdata;
        default: width_cfg_r <= width_cfg_r;
      endcase
    end
  end

  // Derived geometry and the divider datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r   <= mndf_pkg::RESET_SIZE;
      eff_h_r   <= mndf_pkg::RESET_SIZE;
      pixels_r  <= mndf_pkg::RESET_PIXELS;
      total_r   <= mndf_pkg::RESET_TOTAL;
      bit_idx_r <= '0;
      rem_r     <= '0;
      quo_r     <= '0;
    end else begin
      case (state_r)
        mndf_pkg::GEOM_SIZE: begin
          eff_w_r <= clamp_w;
          eff_h_r <= clamp_h;
        end
        mndf_pkg::GEOM_MUL: begin
          pixels_r <= prod[mndf_pkg::POS_BITS-1:0];
        end
        mndf_pkg::GEOM_TOTAL: begin
          total_r <= pixels_r + mndf_pkg::POS_BITS'(eff_w_r) + mndf_pkg::POS_BITS'(1);
        end
        mndf_pkg::GEOM_CHECK: begin
          bit_idx_r <= mndf_pkg::DIV_CNT_BITS'(mndf_pkg::POS_BITS - 1);
          rem_r     <= '0;
          quo_r     <= '0;
        end
        mndf_pkg::GEOM_DIV: begin
          rem_r     <= rem_nxt;
          quo_r     <= quo_nxt;
          bit_idx_r <= bit_idx_r - mndf_pkg::DIV_CNT_BITS'(1);
        end
        default: begin
          rem_r <= rem_r;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/mndf_front.sv
// ----------------------------------------------------------------------------
// mndf_front: sample intake, line stores and 3x3 window
// Tracks the item position, reads and rewrites both line stores, shifts the
// window and queues a masked window for every item that completes a pixel.
// ----------------------------------------------------------------------------
module mndf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  mndf_in_if.sink                          in_chan,
  input  mndf_pkg::geom_ctl_t              geom,
  input  logic [mndf_pkg::QCNT_BITS-1:0]   q_count,
  output logic                             q_push,
  output mndf_pkg::win_entry_t             q_entry,
  output logic [mndf_pkg::POS_BITS-1:0]    pos
);

  logic [mndf_pkg::POS_BITS-1:0] p_r;
  logic [mndf_pkg::COL_BITS-1:0] col_r;
  logic [mndf_pkg::ROW_BITS-1:0] row_r;

  logic                              f1_valid_r;
  logic [mndf_pkg::COL_BITS-1:0]     f1_col_r;
  mndf_pkg::sample_t                 f1_v_r;
  logic                              f1_res_r;
  logic [mndf_pkg::COORD_BITS-1:0]   f1_qr_r, f1_qc_r;
  logic                              f1_left_r, f1_right_r, f1_top_r, f1_bot_r;
  logic                              f1_done_r;
  mndf_pkg::sample_t                 win_r [9];

  logic                              accept;
  logic [mndf_pkg::QCNT_BITS:0]      occupancy;
  logic [mndf_pkg::CFG_DATA_BITS-1:0] w_m1, h_m1;
  logic                              col_zero, col_last, last_item, has_res;
  logic [mndf_pkg::ROW_BITS-1:0]     qr_full;
  logic [mndf_pkg::CFG_DATA_BITS-1:0] qc_full;
  mndf_pkg::sample_t                 v;
  mndf_pkg::sample_t                 upper_rd, lower_rd;
  mndf_pkg::sample_t                 nw [9];

  // Admit an item only while sizes are settled and the queue has room for it.
  assign occupancy     = {1'b0, q_count} + (mndf_pkg::QCNT_BITS + 1)'(f1_valid_r);
  assign in_chan.ready = !geom.busy &&
                         (occupancy < (mndf_pkg::QCNT_BITS + 1)'(mndf_pkg::QUEUE_DEPTH));
  assign accept        = in_chan.valid && in_chan.ready;
  assign pos           = p_r;

  // Classify the incoming item by its place in the frame.
  always_comb begin
    w_m1      = geom.eff_w - mndf_pkg::CFG_DATA_BITS'(1);
    h_m1      = geom.eff_h - mndf_pkg::CFG_DATA_BITS'(1);
    col_zero  = (col_r == '0);
    col_last  = ({1'b0, col_r} == w_m1);
    last_item = ((p_r + mndf_pkg::POS_BITS'(1)) == geom.total);
    has_res   = (row_r >= mndf_pkg::ROW_BITS'(2)) ||
                ((row_r == mndf_pkg::ROW_BITS'(1)) && !col_zero);
    qr_full   = col_zero ? (row_r - mndf_pkg::ROW_BITS'(2))
                         : (row_r - mndf_pkg::ROW_BITS'(1));
    qc_full   = col_zero ? w_m1 : ({1'b0, col_r} - mndf_pkg::CFG_DATA_BITS'(1));
    v         = (row_r < geom.eff_h) ? in_chan.sample_value : '0;
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r   <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (geom.load) begin
      p_r   <= geom.clear ? '0 : p_r;
      col_r <= geom.col;
      row_r <= geom.row;
    end else if (accept) begin
      if (last_item) begin
        p_r   <= '0;
        col_r <= '0;
        row_r <= '0;
      end else begin
        p_r <= p_r + mndf_pkg::POS_BITS'(1);
        if (col_last) begin
          col_r <= '0;
          row_r <= row_r + mndf_pkg::ROW_BITS'(1);
        end else begin
          col_r <= col_r + mndf_pkg::COL_BITS'(1);
        end
      end
    end
  end

  // Stage between the line store read and the window update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_col_r   <= col_r;
      f1_v_r     <= v;
      f1_res_r   <= has_res;
      f1_qr_r    <= qr_full[mndf_pkg::COORD_BITS-1:0];
      f1_qc_r    <= qc_full[mndf_pkg::COORD_BITS-1:0];
      f1_left_r  <= (qc_full == '0);
      f1_right_r <= (qc_full == w_m1);
      f1_top_r   <= (qr_full == '0);
      f1_bot_r   <= (qr_full == h_m1);
      f1_done_r  <= (qc_full == w_m1) && (qr_full == h_m1);
    end
  end

  // Line store holding samples two rows back.
  mndf_ram #(
    .WIDTH (mndf_pkg::SAMPLE_BITS),
    .DEPTH (mndf_pkg::MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (f1_valid_r),
    .waddr (f1_col_r),
    .wdata (lower_rd),
    .re    (accept),
    .raddr (col_r),
    .rdata (upper_rd)
  );

  // Line store holding samples one row back.
  mndf_ram #(
    .WIDTH (mndf_pkg::SAMPLE_BITS),
    .DEPTH (mndf_pkg::MAX_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (f1_valid_r),
    .waddr (f1_col_r),
    .wdata (f1_v_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (lower_rd)
  );

  // Shifted window: columns move left, the new column enters on the right.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      nw[i] = win_r[i + 3];
    end
    nw[6] = upper_rd;
    nw[7] = lower_rd;
    nw[8] = f1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (f1_valid_r) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= nw[i];
      end
    end
  end

  // Force positions outside the frame to zero and hand the window on.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (((i / 3 == 0) && f1_left_r) || ((i / 3 == 2) && f1_right_r) ||
          ((i % 3 == 0) && f1_top_r)  || ((i % 3 == 2) && f1_bot_r)) begin
        q_entry.win[i] = '0;
      end else begin
        q_entry.win[i] = nw[i];
      end
    end
    q_entry.qr   = f1_qr_r;
    q_entry.qc   = f1_qc_r;
    q_entry.done = f1_done_r;
  end

  assign q_push = f1_valid_r && f1_res_r;

endmodule

>>> rtl/core/mndf_queue.sv
// ----------------------------------------------------------------------------
// mndf_queue: short window queue between front and back end
// A small FIFO of masked windows so either side can stall on its own.
// ----------------------------------------------------------------------------
module mndf_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  mndf_pkg::win_entry_t            push_entry,
  input  logic                            pop,
  output mndf_pkg::win_entry_t            head,
  output logic [mndf_pkg::QCNT_BITS-1:0]  count
);

  mndf_pkg::win_entry_t              store_r [mndf_pkg::QUEUE_DEPTH];
  logic [mndf_pkg::QPTR_BITS-1:0]    wr_ptr_r, rd_ptr_r;
  logic [mndf_pkg::QCNT_BITS-1:0]    count_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + mndf_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + mndf_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + mndf_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count_r <= count_r - mndf_pkg::QCNT_BITS'(1);
      end
    end
  end

  assign head  = store_r[rd_ptr_r];
  assign count = count_r;

endmodule

>>> rtl/core/mndf_back.sv
// ----------------------------------------------------------------------------
// mndf_back: gradient evaluation and result register
// Takes masked windows from the queue, forms the eight absolute differences
// to the center, reduces them to their maximum and presents the result.
// ----------------------------------------------------------------------------
module mndf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  mndf_out_if.source                      out_chan,
  input  mndf_pkg::win_entry_t            head,
  input  logic [mndf_pkg::QCNT_BITS-1:0]  q_count,
  output logic                            pop
);

  logic                            advance;
  logic                            b1_valid_r;
  mndf_pkg::sample_t               diff_r [8];
  logic [mndf_pkg::COORD_BITS-1:0] b1_qr_r, b1_qc_r;
  logic                            b1_done_r;

  logic                            out_valid_r;
  logic [mndf_pkg::GRAD_BITS-1:0]  grad_r;
  logic [mndf_pkg::COORD_BITS-1:0] row_r, col_r;
  logic                            done_r;

  mndf_pkg::sample_t               diff [8];
  mndf_pkg::sample_t               lvl1 [4];
  mndf_pkg::sample_t               lvl2 [2];
  mndf_pkg::sample_t               best;

  // The whole back end moves when the result register is free or being taken.
  assign advance = !out_valid_r || out_chan.ready;
  assign pop     = advance && (q_count != '0);

  // Absolute differences of the eight neighbors to the center.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (i < 4) begin
        diff[i] = (head.win[i] > head.win[4]) ? head.win[i] - head.win[4]
                                              : head.win[4] - head.win[i];
      end else if (i > 4) begin
        diff[i - 1] = (head.win[i] > head.win[4]) ? head.win[i] - head.win[4]
                                                  : head.win[4] - head.win[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 8; i++) begin
        diff_r[i] <= diff[i];
      end
      b1_qr_r   <= head.qr;
      b1_qc_r   <= head.qc;
      b1_done_r <= head.done;
    end
  end

  // Maximum over the eight differences as a three-level tree.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = (diff_r[2*i] > diff_r[2*i+1]) ? diff_r[2*i] : diff_r[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    best = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b1_valid_r) begin
      grad_r <= best;
      row_r  <= b1_qr_r;
      col_r  <= b1_qc_r;
      done_r <= b1_done_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.gradient   = grad_r;
  assign out_chan.pixel_row  = row_r;
  assign out_chan.pixel_col  = col_r;
  assign out_chan.frame_done = done_r;

endmodule

>>> rtl/core/max_neighbor_difference_filter.sv
// ----------------------------------------------------------------------------
// max_neighbor_difference_filter: 3x3 maximum neighbor difference
// Path: the item completing a pixel's window (one row and one column later)
// passes the front stage, window queue, difference and output registers.
// Throughput: one item per cycle while the queue has room; a size register
// write holds the input off while the geometry unit divides the position.
// Reset (synchronous, rst_n low): 256x256 frame, position zero, empty queue;
// the line stores are not cleared.
// ----------------------------------------------------------------------------
module max_neighbor_difference_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  mndf_in_if.sink                             in_chan,
  mndf_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [mndf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mndf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  mndf_pkg::geom_ctl_t               geom_ctl;
  logic [mndf_pkg::POS_BITS-1:0]     pos;
  logic                              q_push, q_pop;
  mndf_pkg::win_entry_t              q_entry, q_head;
  logic [mndf_pkg::QCNT_BITS-1:0]    q_count;

  // Frame geometry and position recalculation.
  mndf_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pos       (pos),
    .ctl       (geom_ctl)
  );

  // Intake, line stores and window.
  mndf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .geom    (geom_ctl),
    .q_count (q_count),
    .q_push  (q_push),
    .q_entry (q_entry),
    .pos     (pos)
  );

  // Window queue.
  mndf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .count      (q_count)
  );

  // Gradient evaluation and result register.
  mndf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_chan (out_chan),
    .head     (q_head),
    .q_count  (q_count),
    .pop      (q_pop)
  );

  // A size write holds off the input on the following cycle.
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_chan.ready)
    else $error("input taken right after a size register write");

  // The front never pushes into a full queue.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count != mndf_pkg::QCNT_FULL))
    else $error("window queue overflow");

  // A pushed window is held in the queue on the next cycle.
  a_queue_keeps_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (q_count != '0))
    else $error("pushed window lost");

  // A position reload never coincides with an accepted item.
  a_load_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    geom_ctl.load |-> !(in_chan.valid && in_chan.ready))
    else $error("position reload during an input transfer");

endmodule
